>>> rtl/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority task scheduler package
// Shared widths, operation and mode codes, and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int TICK_BITS_DEF = 32;

  localparam int OP_W        = 3;
  localparam int DLY_W       = 32;
  localparam int TASK_W      = 3;
  localparam int PRIO_W      = 7;
  localparam int PRIO_SLOTS  = 8;
  localparam int PRIO_FLD_W  = PRIO_W * PRIO_SLOTS;
  localparam int MASK_W      = 8;
  localparam int TICK_OUT_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = PRIO_FLD_W;
  localparam int MODE_W      = 2;

  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELAY    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUSPEND  = 3'd2;
  localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_READY     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAITING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_TASK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRIORITIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOSTART_MASK  = 2'd2;

  typedef struct packed {
    logic latch;
    logic apply;
    logic pick;
    logic decr;
    logic load_out;
  } pts_cmd_t;

  typedef struct packed {
    logic op_start;
    logic op_tick;
    logic op_known;
    logic out_free;
  } pts_status_t;

endpackage
`default_nettype wire

>>> rtl/pts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one operation through apply, pick, delay countdown and result
// load, and holds off the input channel while an operation is in flight.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  pts_pkg::pts_status_t status,
  output pts_pkg::pts_cmd_t    cmd
);
  import pts_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_DECR  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        // Start and unrecognised operations make no pick.
        if (status.op_start || !status.op_known) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = status.op_tick ? S_DECR : S_DONE;
      end
      S_DECR: begin
        cmd.decr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pts_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler datapath
// Configuration registers, task table, priority pick, delay countdown and
// the result register.
// ----------------------------------------------------------------------------
module pts_dpath #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pts_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire  [pts_pkg::OP_W-1:0]         opcode,
  input  wire  [pts_pkg::DLY_W-1:0]        delay_ticks,
  input  wire  [pts_pkg::TASK_W-1:0]       target_task,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pts_pkg::TASK_W-1:0]       running_task,
  output logic                             running_valid,
  output logic                             switched,
  output logic [pts_pkg::TICK_OUT_W-1:0]   tick_count,
  input  pts_pkg::pts_cmd_t                cmd,
  output pts_pkg::pts_status_t             status
);
  import pts_pkg::*;

  localparam int IDXW = $clog2(MAX_TASKS);
  // Only the first eight entries can ever lie at or below the idle slot.
  localparam int SCAN = (MAX_TASKS < PRIO_SLOTS) ? MAX_TASKS : PRIO_SLOTS;

  // Configuration
  logic [TASK_W-1:0]     user_task_count;
  logic [PRIO_FLD_W-1:0] task_priorities;
  logic [MASK_W-1:0]     autostart_mask;

  // Task table and scheduler state
  logic [MODE_W-1:0]    mode [MAX_TASKS];
  logic [TICK_BITS-1:0] sleep_left [MAX_TASKS];
  logic                 cur_valid;
  logic [IDXW-1:0]      current;
  logic [IDXW-1:0]      chosen;
  logic [TICK_BITS-1:0] ticks;
  logic                 sw;

  // Latched operation
  logic [OP_W-1:0]   op;
  logic [DLY_W-1:0]  dly;
  logic [TASK_W-1:0] tgt;

  logic [IDXW-1:0]            idle;
  logic [IDXW-1:0]            best_idx;
  logic [PRIO_W-1:0]          best_prio;
  logic                       best_found;
  logic [IDXW-1:0]            pick_idx;
  logic                       pick_change;
  logic [TICK_BITS-1:0]       dly_fit;
  logic [DLY_W+TICK_BITS-1:0] dly_wide;
  logic [TICK_BITS+TICK_OUT_W-1:0] ticks_wide;
  logic [IDXW+TASK_W-1:0]     cur_wide;
  logic [MAX_TASKS+MASK_W-1:0] mask_wide;
  logic                       tgt_in_range;
  logic [IDXW-1:0]            tgt_idx;
  logic [IDXW+TASK_W-1:0]     tgt_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      user_task_count <= '0;
      task_priorities <= '0;
      autostart_mask  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_USER_TASK_COUNT: user_task_count <= cfg_data[TASK_W-1:0];
        CFG_TASK_PRIORITIES: task_priorities <= cfg_data[PRIO_FLD_W-1:0];
        CFG_AUTOSTART_MASK:  autostart_mask  <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if ({29'b0, user_task_count} < 32'(MAX_TASKS)) begin
      idle = IDXW'(user_task_count);
    end else begin
      idle = IDXW'(MAX_TASKS - 1);
    end
  end

  assign dly_wide   = {{TICK_BITS{1'b0}}, dly};
  assign dly_fit    = dly_wide[TICK_BITS-1:0];
  assign ticks_wide = {{TICK_OUT_W{1'b0}}, ticks};
  assign cur_wide   = {{TASK_W{1'b0}}, current};
  assign mask_wide  = {{MAX_TASKS{1'b0}}, autostart_mask};
  assign tgt_wide   = {{IDXW{1'b0}}, tgt};
  assign tgt_idx    = tgt_wide[IDXW-1:0];
  assign tgt_in_range = ({29'b0, tgt} < 32'(MAX_TASKS));

  // Highest priority ready task at or below the idle slot; the first one
  // found wins a tie.
  always_comb begin
    best_found = 1'b0;
    best_prio  = '0;
    best_idx   = chosen;
    for (int i = 0; i < SCAN; i++) begin
      if ((32'(i) <= 32'(idle)) && (mode[i] == MODE_READY) &&
          (!best_found || (task_priorities[PRIO_W*i +: PRIO_W] > best_prio))) begin
        best_found = 1'b1;
        best_prio  = task_priorities[PRIO_W*i +: PRIO_W];
        best_idx   = IDXW'(i);
      end
    end
  end

  assign pick_idx    = best_idx;
  assign pick_change = !cur_valid || (pick_idx != current);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= opcode;
      dly <= delay_ticks;
      tgt <= target_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        mode[i]       <= MODE_SUSPENDED;
        sleep_left[i] <= '0;
      end
      cur_valid <= 1'b0;
      current   <= '0;
      chosen    <= '0;
      ticks     <= '0;
      sw        <= 1'b0;
    end else begin
      if (cmd.latch) begin
        sw <= 1'b0;
      end
      if (cmd.apply) begin
        case (op)
          OP_START: begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              if (32'(i) < 32'(idle)) begin
                mode[i] <= mask_wide[i] ? MODE_READY : MODE_SUSPENDED;
              end else if (32'(i) == 32'(idle)) begin
                mode[i] <= MODE_READY;
              end else begin
                mode[i] <= MODE_SUSPENDED;
              end
              sleep_left[i] <= '0;
            end
            cur_valid <= 1'b0;
            current   <= '0;
            ticks     <= '0;
          end
          OP_DELAY: begin
            if (cur_valid) begin
              mode[current]       <= MODE_WAITING;
              sleep_left[current] <= dly_fit;
            end
          end
          OP_SUSPEND: begin
            if (cur_valid) begin
              mode[current] <= MODE_SUSPENDED;
            end
          end
          OP_ACTIVATE: begin
            if (tgt_in_range) begin
              mode[tgt_idx] <= MODE_READY;
            end
          end
          OP_TICK: begin
            ticks <= ticks + TICK_BITS'(1);
          end
          default: begin
          end
        endcase
      end
      if (cmd.pick) begin
        chosen <= pick_idx;
        sw     <= pick_change;
        if (pick_change) begin
          current        <= pick_idx;
          cur_valid      <= 1'b1;
          mode[pick_idx] <= MODE_READY;
        end
      end
      if (cmd.decr) begin
        // Countdown of the waiting user tasks, after the pick of this tick.
        for (int i = 0; i < SCAN; i++) begin
          if ((32'(i) < 32'(idle)) && (mode[i] == MODE_WAITING)) begin
            sleep_left[i] <= sleep_left[i] - TICK_BITS'(1);
            if (sleep_left[i] == TICK_BITS'(1)) begin
              mode[i] <= MODE_READY;
            end
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      running_task  <= cur_valid ? cur_wide[TASK_W-1:0] : '0;
      running_valid <= cur_valid;
      switched      <= sw;
      tick_count    <= ticks_wide[TICK_OUT_W-1:0];
    end
  end

  assign status.op_start = (op == OP_START);
  assign status.op_tick  = (op == OP_TICK);
  assign status.op_known = (op == OP_START) || (op == OP_DELAY) || (op == OP_SUSPEND) ||
                           (op == OP_ACTIVATE) || (op == OP_TICK);
  assign status.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

>>> rtl/priority_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority task scheduler
// Fixed-priority preemptive scheduler core: a table of task modes and delay
// counts driven by start, delay, suspend, activate and tick operations.
// ----------------------------------------------------------------------------
// One operation is in flight at a time and yields exactly one result
// transaction. Start and unrecognised operations pass only the apply state
// before the result load; delay, suspend and activate also pass a priority
// pick over the ready entries at or below the idle slot, and a tick also a
// countdown state over the waiting tasks. The input is stalled from
// acceptance until the result is loaded, so a new transaction is taken only
// after the last one's result is loaded; a result that is held by out_stall
// delays the load of the next one. Configuration writes are always taken and
// must only be issued while no operation is in flight.
module priority_task_scheduler_top #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TICK_BITS = pts_pkg::TICK_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [pts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [pts_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [pts_pkg::OP_W-1:0]         opcode,
  input  wire  [pts_pkg::DLY_W-1:0]        delay_ticks,
  input  wire  [pts_pkg::TASK_W-1:0]       target_task,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [pts_pkg::TASK_W-1:0]       running_task,
  output logic                             running_valid,
  output logic                             switched,
  output logic [pts_pkg::TICK_OUT_W-1:0]   tick_count
);
  import pts_pkg::*;

  pts_cmd_t    cmd;
  pts_status_t status;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pts_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_BITS (TICK_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .delay_ticks   (delay_ticks),
    .target_task   (target_task),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .running_task  (running_task),
    .running_valid (running_valid),
    .switched      (switched),
    .tick_count    (tick_count),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
`default_nettype wire

>>> tb/pts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler checker
// Watches the configuration, operation and result channels, keeps its own
// copy of the task table and compares every result transaction with the
// dispatch it predicts.
// ----------------------------------------------------------------------------
module pts_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire  [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  input  wire                             in_stall,
  input  wire  [pts_pkg::OP_W-1:0]        opcode,
  input  wire  [pts_pkg::DLY_W-1:0]       delay_ticks,
  input  wire  [pts_pkg::TASK_W-1:0]      target_task,
  input  wire                             out_valid,
  input  wire                             out_stall,
  input  wire  [pts_pkg::TASK_W-1:0]      running_task,
  input  wire                             running_valid,
  input  wire                             switched,
  input  wire  [pts_pkg::TICK_OUT_W-1:0]  tick_count,
  output int                              fail_count,
  output int                              pending
);
  import pts_pkg::*;

  typedef struct packed {
    logic [TASK_W-1:0]     run_task;
    logic                  run_valid;
    logic                  sw;
    logic [TICK_OUT_W-1:0] ticks;
  } dispatch_t;

  logic [TASK_W-1:0]     n_user;
  logic [PRIO_FLD_W-1:0] prio_field;
  logic [MASK_W-1:0]     start_mask;

  logic [MODE_W-1:0]     mode_tbl  [MAX_TASKS_DEF];
  logic [TICK_OUT_W-1:0] sleep_tbl [MAX_TASKS_DEF];
  logic                  cur_valid;
  logic [TASK_W-1:0]     cur_idx;
  logic [TASK_W-1:0]     chosen_idx;
  logic [TICK_OUT_W-1:0] tick_ctr;

  dispatch_t predicted_dispatch [$];
  dispatch_t want;
  dispatch_t next_dispatch;
  int        mismatches = 0;
  int        outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Highest priority ready task at or below the idle slot wins; the strict
  // comparison gives ties to the lowest index. With nothing ready the last
  // choice stands.
  function automatic logic pick_next();
    int                best;
    logic [PRIO_W-1:0] p;
    best = -1;
    for (int i = 0; i <= int'(n_user); i++) begin
      p = prio_field[PRIO_W*i +: PRIO_W];
      if (mode_tbl[i] == MODE_READY && int'(p) > best) begin
        best       = int'(p);
        chosen_idx = TASK_W'(i);
      end
    end
    if (!cur_valid || chosen_idx != cur_idx) begin
      cur_idx           = chosen_idx;
      cur_valid         = 1'b1;
      mode_tbl[cur_idx] = MODE_READY;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic schedule_op(input logic [OP_W-1:0] op, input logic [DLY_W-1:0] dly,
                             input logic [TASK_W-1:0] tgt, output dispatch_t res);
    logic sw;
    sw = 1'b0;
    case (op)
      OP_START: begin
        for (int i = 0; i < MAX_TASKS_DEF; i++) begin
          mode_tbl[i]  = (i < int'(n_user) && start_mask[i]) ? MODE_READY : MODE_SUSPENDED;
          sleep_tbl[i] = '0;
        end
        mode_tbl[n_user] = MODE_READY;
        cur_valid        = 1'b0;
        cur_idx          = '0;
        tick_ctr         = '0;
      end
      OP_DELAY: begin
        if (cur_valid) begin
          mode_tbl[cur_idx]  = MODE_WAITING;
          sleep_tbl[cur_idx] = dly;
        end
        sw = pick_next();
      end
      OP_SUSPEND: begin
        if (cur_valid) begin
          mode_tbl[cur_idx] = MODE_SUSPENDED;
        end
        sw = pick_next();
      end
      OP_ACTIVATE: begin
        mode_tbl[tgt] = MODE_READY;
        sw = pick_next();
      end
      OP_TICK: begin
        tick_ctr = tick_ctr + 1'b1;
        sw = pick_next();
        // The countdown follows the pick, so a task woken here can only be picked by a later operation.
        for (int i = 0; i < int'(n_user); i++) begin
          if (mode_tbl[i] == MODE_WAITING) begin
            sleep_tbl[i] = sleep_tbl[i] - 1'b1;
            if (sleep_tbl[i] == '0) begin
              mode_tbl[i] = MODE_READY;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.run_task  = cur_valid ? cur_idx : '0;
    res.run_valid = cur_valid;
    res.sw        = sw;
    res.ticks     = tick_ctr;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      n_user     = '0;
      prio_field = '0;
      start_mask = '0;
      for (int i = 0; i < MAX_TASKS_DEF; i++) begin
        mode_tbl[i]  = MODE_SUSPENDED;
        sleep_tbl[i] = '0;
      end
      cur_valid  = 1'b0;
      cur_idx    = '0;
      chosen_idx = '0;
      tick_ctr   = '0;
      predicted_dispatch.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_dispatch.size() == 0) begin
          report_mismatch($sformatf("result transaction with nothing outstanding, task %0d",
                                    running_task));
        end else begin
          want = predicted_dispatch.pop_front();
          if (running_task !== want.run_task)
            report_mismatch($sformatf("running_task expected %0d got %0d",
                                      want.run_task, running_task));
          if (running_valid !== want.run_valid)
            report_mismatch($sformatf("running_valid expected %0d got %0d",
                                      want.run_valid, running_valid));
          if (switched !== want.sw)
            report_mismatch($sformatf("switched expected %0d got %0d", want.sw, switched));
          if (tick_count !== want.ticks)
            report_mismatch($sformatf("tick_count expected %0d got %0d",
                                      want.ticks, tick_count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_USER_TASK_COUNT: n_user     = cfg_data[TASK_W-1:0];
          CFG_TASK_PRIORITIES: prio_field = cfg_data[PRIO_FLD_W-1:0];
          CFG_AUTOSTART_MASK:  start_mask = cfg_data[MASK_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        schedule_op(opcode, delay_ticks, target_task, next_dispatch);
        predicted_dispatch.push_back(next_dispatch);
      end
    end
    outstanding = predicted_dispatch.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority task scheduler testbench
// Drives directed and random scheduler operations under several register
// settings, with random idling on both channels, a long result hold-off and
// full drains between phases; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top;
  import pts_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int NUM_PHASES      = 15;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PRESSURE_PHASE  = 3;
  localparam int CALM_PHASE      = 5;
  localparam int SETTLE_CYCLES   = 10;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_TICK + 1'b1;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

  // Task 0 below the tied pair 1 and 2, idle task 3 lowest.
  localparam logic [CFG_DATA_W-1:0] PRIO_DEMO =
    (56'd10) | (56'd20 << PRIO_W) | (56'd20 << (2*PRIO_W)) | (56'd5 << (3*PRIO_W));

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         opcode;
  logic [DLY_W-1:0]        delay_ticks;
  logic [TASK_W-1:0]       target_task;
  logic                    out_valid;
  logic                    out_stall;
  logic [TASK_W-1:0]       running_task;
  logic                    running_valid;
  logic                    switched;
  logic [TICK_OUT_W-1:0]   tick_count;

  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  logic calm;
  logic pressure;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  priority_task_scheduler_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .delay_ticks   (delay_ticks),
    .target_task   (target_task),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .running_task  (running_task),
    .running_valid (running_valid),
    .switched      (switched),
    .tick_count    (tick_count)
  );

  pts_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .delay_ticks   (delay_ticks),
    .target_task   (target_task),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .running_task  (running_task),
    .running_valid (running_valid),
    .switched      (switched),
    .tick_count    (tick_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL priority_task_scheduler_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, except for one long hold-off during the
  // pressure phase and none at all during the calm phase.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (pressure && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 10);
      end
    end
  end

  // Returns just after the transaction is taken; valid stays high until the
  // caller's next falling edge decides what comes next.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [DLY_W-1:0] dly,
                         input logic [TASK_W-1:0] tgt);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    delay_ticks <= dly;
    target_task <= tgt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [TASK_W-1:0] n, input logic [CFG_DATA_W-1:0] prio,
                           input logic [MASK_W-1:0] mask);
    write_reg(CFG_USER_TASK_COUNT, CFG_DATA_W'(n));
    write_reg(CFG_TASK_PRIORITIES, prio);
    write_reg(CFG_AUTOSTART_MASK, CFG_DATA_W'(mask));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    logic [OP_W-1:0]       op;
    logic [DLY_W-1:0]      dly;
    logic [TASK_W-1:0]     n_cfg;
    logic [CFG_DATA_W-1:0] prio_cfg;
    logic [MASK_W-1:0]     mask_cfg;
    int                    r;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = '0;
    delay_ticks = '0;
    target_task = '0;
    calm        = 1'b0;
    pressure    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any start: nothing is ready, so the kept choice becomes current.
    send_op(OP_TICK, '0, '0);
    send_op(OP_FIRST_UNUSED, '1, '1);
    drain();

    configure(3'd3, PRIO_DEMO, 8'b0000_0101);
    send_op(OP_START, '0, '0);
    send_op(OP_DELAY, '0, '0);          // no current task: only a pick
    send_op(OP_START, '0, '0);
    send_op(OP_SUSPEND, '0, '0);        // no current task: only a pick
    send_op(OP_DELAY, '0, '0);          // zero delay; task 2 is activated again before any tick
    send_op(OP_ACTIVATE, '0, 3'd1);
    send_op(OP_ACTIVATE, '0, 3'd2);     // equal priority, lower index keeps it
    send_op(OP_ACTIVATE, '0, '1);       // beyond the idle slot, never scanned
    send_op(OP_DELAY, '1, '0);
    send_op(OP_DELAY, 32'd1, '0);
    send_op(OP_TICK, '0, '0);
    send_op(OP_TICK, '0, '0);
    repeat (4) send_op(OP_SUSPEND, '0, '0);  // ends with the idle task suspended
    send_op(OP_LAST_UNUSED, '0, '0);
    drain();

    configure('1, '1, '1);
    send_op(OP_START, '0, '0);
    send_op(OP_TICK, '0, '0);
    send_op(OP_ACTIVATE, '0, '0);
    drain();

    configure('0, '0, '0);
    send_op(OP_START, '0, '0);
    send_op(OP_ACTIVATE, '0, 3'd5);
    send_op(OP_TICK, '0, '0);
    send_op(OP_DELAY, $urandom, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      pressure = 1'b0;
      r = $urandom_range(9);
      n_cfg = (r == 0) ? '0 : (r == 1) ? '1 : TASK_W'($urandom_range(6, 1));
      r = $urandom_range(9);
      if (r == 0) begin
        prio_cfg = '0;
      end else if (r == 1) begin
        prio_cfg = '1;
      end else if (r < 5) begin
        prio_cfg = CFG_DATA_W'({$urandom, $urandom});
      end else begin
        // Narrow priorities give plenty of ties.
        prio_cfg = '0;
        for (int s = 0; s < PRIO_SLOTS; s++)
          prio_cfg[PRIO_W*s +: PRIO_W] = PRIO_W'($urandom_range(3));
      end
      r = $urandom_range(9);
      mask_cfg = (r == 0) ? '0 : (r == 1) ? '1 : MASK_W'($urandom);
      configure(n_cfg, prio_cfg, mask_cfg);
      calm     = (ph == CALM_PHASE);
      pressure = (ph == PRESSURE_PHASE);
      send_op(OP_START, '0, '0);
      for (int k = 1; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(99);
        if (r < 40) op = OP_TICK;
        else if (r < 60) op = OP_ACTIVATE;
        else if (r < 78) op = OP_DELAY;
        else if (r < 90) op = OP_SUSPEND;
        else if (r < 94) op = OP_START;
        else op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
        r = $urandom_range(9);
        if (r == 0) dly = '0;
        else if (r == 1) dly = '1;
        else if (r < 4) dly = $urandom;
        else dly = DLY_W'($urandom_range(6, 1));
        send_op(op, dly, TASK_W'($urandom_range(7)));
      end
    end
    drain();
    calm     = 1'b0;
    pressure = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS priority_task_scheduler_top");
    end else begin
      $display("FAIL priority_task_scheduler_top");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_dpath.sv
rtl/priority_task_scheduler_top.sv
tb/pts_checker.sv
tb/tb_top.sv
